[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for clocked concurrent assertions with synchronous reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define ASSERT_SYNC(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// A condition that must never be true outside reset.
`define ASSERT_NEVER(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

[rtl/itd_pkg.sv]
// ----------------------------------------------------------------------------
// Integer to decimal text package
// Types and constants shared by the converter core and its divide unit.
// ----------------------------------------------------------------------------
package itd_pkg;

  // Character codes, six bits wide as on the output port.
  localparam logic [5:0] CHAR_ZERO  = 6'd48;
  localparam logic [5:0] CHAR_MINUS = 6'd45;

  // Decimal digits of a 32-bit magnitude.
  localparam int unsigned MAX_DIGITS = 10;
  localparam int unsigned DIGIT_W    = 4;
  localparam int unsigned CNT_W      = 4;
  localparam int unsigned MAG_W      = 32;

  // Reciprocal of ten: floor(n / 10) = (n * RECIP10) >> RECIP_SHIFT for 32-bit n.
  localparam logic [31:0] RECIP10     = 32'hCCCC_CCCD;
  localparam int unsigned RECIP_SHIFT = 35;
  localparam int unsigned QUOT_W      = 64 - RECIP_SHIFT;

  // Result of one divide-by-ten step.
  typedef struct packed {
    logic [MAG_W-1:0]   quot;
    logic [DIGIT_W-1:0] rem;
  } div_result_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_REM,
    ST_SIGN,
    ST_DIGITS
  } state_t;

endpackage

[rtl/integer_to_decimal_text_core.sv]
// ----------------------------------------------------------------------------
// Integer to decimal text core
// Converts a signed 32-bit integer to its ASCII decimal text, one character
// per output beat, most significant first, with a leading '-' when negative.
// The input channel takes one value while the block is idle; in_ready stays
// low until the last character of that value has been taken. Each value
// first runs its digits through one shared divide-by-ten unit, one step per
// digit (reciprocal multiply, then remainder), pushing them onto a digit
// stack, all before its first character goes out. Characters then leave
// one per cycle while out_ready is high, the last one flagged by last.
// When the receiver stalls, out_valid and the character hold until the
// beat is taken. Reset returns the sequencer to idle and drops any value
// in progress.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module integer_to_decimal_text_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [5:0]         char_code,
  output logic               last
);

  itd_pkg::state_t state;
  itd_pkg::state_t state_next;

  logic [itd_pkg::MAG_W-1:0]   mag;
  logic                        neg;
  logic [itd_pkg::CNT_W-1:0]   cnt;
  logic [itd_pkg::CNT_W-1:0]   cnt_inc;
  logic [itd_pkg::DIGIT_W-1:0] stack [itd_pkg::MAX_DIGITS];
  logic [itd_pkg::MAG_W-1:0]   raw;
  logic                        div_load;
  logic                        in_beat;
  logic                        out_beat;
  logic                        digits_done;
  logic                        cnt_in_range;
  itd_pkg::div_result_t        div_res;

  assign raw      = $unsigned(value);
  assign in_beat  = in_valid && in_ready;
  assign out_beat = out_valid && out_ready;
  assign cnt_inc  = cnt + {{(itd_pkg::CNT_W-1){1'b0}}, 1'b1};
  assign digits_done = (div_res.quot == '0) ||
                       (cnt_inc == itd_pkg::CNT_W'(itd_pkg::MAX_DIGITS));

  // Shared divide-by-ten unit.
  itd_div10 u_div10 (
    .clk      (clk),
    .load     (div_load),
    .dividend (mag),
    .res      (div_res)
  );

  // Next-state logic of the sequencer.
  always_comb begin
    state_next = state;
    case (state)
      itd_pkg::ST_IDLE: begin
        if (in_beat) state_next = itd_pkg::ST_MUL;
      end
      itd_pkg::ST_MUL: begin
        state_next = itd_pkg::ST_REM;
      end
      itd_pkg::ST_REM: begin
        if (digits_done) begin
          state_next = neg ? itd_pkg::ST_SIGN : itd_pkg::ST_DIGITS;
        end else begin
          state_next = itd_pkg::ST_MUL;
        end
      end
      itd_pkg::ST_SIGN: begin
        if (out_beat) state_next = itd_pkg::ST_DIGITS;
      end
      itd_pkg::ST_DIGITS: begin
        if (out_beat && (cnt == itd_pkg::CNT_W'(1))) state_next = itd_pkg::ST_IDLE;
      end
      default: state_next = itd_pkg::ST_IDLE;
    endcase
  end

  // Output and control decode of the sequencer.
  always_comb begin
    in_ready  = 1'b0;
    out_valid = 1'b0;
    div_load  = 1'b0;
    char_code = itd_pkg::CHAR_ZERO + {2'b00, stack[0]};
    last      = 1'b0;
    case (state)
      itd_pkg::ST_IDLE: begin
        in_ready = 1'b1;
      end
      itd_pkg::ST_MUL: begin
        div_load = 1'b1;
      end
      itd_pkg::ST_SIGN: begin
        out_valid = 1'b1;
        char_code = itd_pkg::CHAR_MINUS;
      end
      itd_pkg::ST_DIGITS: begin
        out_valid = 1'b1;
        last      = (cnt == itd_pkg::CNT_W'(1));
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= itd_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Digit count: grows on each divide step, shrinks on each digit beat.
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (in_beat) begin
      cnt <= '0;
    end else if (state == itd_pkg::ST_REM) begin
      cnt <= cnt_inc;
    end else if ((state == itd_pkg::ST_DIGITS) && out_beat) begin
      cnt <= cnt - itd_pkg::CNT_W'(1);
    end
  end

  // Magnitude and sign of the value being converted.
  always_ff @(posedge clk) begin
    if (in_beat) begin
      neg <= raw[itd_pkg::MAG_W-1];
      mag <= raw[itd_pkg::MAG_W-1] ? (~raw + itd_pkg::MAG_W'(1)) : raw;
    end else if (state == itd_pkg::ST_REM) begin
      mag <= div_res.quot;
    end
  end

  // Digit stack: pushes least significant first, pops most significant first.
  always_ff @(posedge clk) begin
    if (state == itd_pkg::ST_REM) begin
      stack[0] <= div_res.rem;
      for (int i = 1; i < itd_pkg::MAX_DIGITS; i++) begin
        stack[i] <= stack[i-1];
      end
    end else if ((state == itd_pkg::ST_DIGITS) && out_beat) begin
      for (int i = 0; i < itd_pkg::MAX_DIGITS - 1; i++) begin
        stack[i] <= stack[i+1];
      end
    end
  end

  // In the digit state, the digit count stays between one and the most digits a value can have.
  assign cnt_in_range = (cnt != '0) && (cnt <= itd_pkg::CNT_W'(itd_pkg::MAX_DIGITS));

  // Checks on the sequencer.
  `ASSERT_NEVER(a_ready_excl, clk, rst, in_ready && out_valid, "input taken while emitting")
  `ASSERT_SYNC(a_last_idle, clk, rst, (out_beat && last) |=> in_ready, "not idle after last")
  `ASSERT_SYNC(a_digits_cnt, clk, rst, (state == itd_pkg::ST_DIGITS) |-> cnt_in_range, "bad count")

endmodule

[rtl/itd_div10.sv]
// ----------------------------------------------------------------------------
// Divide-by-ten unit
// Each step: a registered reciprocal multiply, then the remainder.
// ----------------------------------------------------------------------------
module itd_div10 (
  input  logic                       clk,
  input  logic                       load,
  input  logic [itd_pkg::MAG_W-1:0]  dividend,
  output itd_pkg::div_result_t       res
);

  logic [63:0]                 prod;
  logic [itd_pkg::QUOT_W-1:0]  quot;
  logic [itd_pkg::MAG_W-1:0]   quot_ext;
  logic [itd_pkg::MAG_W-1:0]   times10;
  logic [itd_pkg::MAG_W-1:0]   rem_full;

  // Multiply by the reciprocal and keep the quotient bits.
  assign prod = {32'd0, dividend} * {32'd0, itd_pkg::RECIP10};

  always_ff @(posedge clk) begin
    if (load) begin
      quot <= prod[63:itd_pkg::RECIP_SHIFT];
    end
  end

  // Remainder is the dividend less ten times the quotient.
  assign quot_ext = {{(itd_pkg::MAG_W - itd_pkg::QUOT_W){1'b0}}, quot};
  assign times10  = (quot_ext << 3) + (quot_ext << 1);
  assign rem_full = dividend - times10;

  assign res.quot = quot_ext;
  assign res.rem  = rem_full[itd_pkg::DIGIT_W-1:0];

endmodule

[bench/integer_to_decimal_text_core_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Integer to decimal text core testbench
// Feeds signed 32-bit values into the converter and checks every character
// beat against a local predictor of the decimal text. Directed corner values
// come first, then random values of every digit count under several idling
// patterns, including a long receiver hold-off that backs up the input.
// ----------------------------------------------------------------------------
module integer_to_decimal_text_core_tb;

  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned SETTLE_CYCLES = 40;

  // One expected character of the decimal text.
  typedef struct packed {
    logic [5:0] code;
    logic       is_last;
  } text_char_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic signed [31:0] value = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [5:0]         char_code;
  logic               last;

  logic [31:0] values_to_send[$];
  text_char_t  text_expected[$];
  int          error_count = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          hold_req = 0;
  int          hold_ack = 0;
  int          hold_left = 0;

  integer_to_decimal_text_core i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .value     (value),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .char_code (char_code),
    .last      (last)
  );

  always #2 clk = ~clk;

  // Prints one mismatch line and counts it.
  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    error_count++;
  endtask

  // Appends the characters that the text of one value should produce.
  function automatic void predict_text(input logic [31:0] raw);
    logic [31:0] mag;
    logic [3:0]  digit_stack[10];
    int          n_digits;
    text_char_t  ch;
    n_digits = 0;
    // The most negative value wraps to its own unsigned magnitude.
    mag = raw[31] ? (32'd0 - raw) : raw;
    do begin
      digit_stack[n_digits] = 4'(mag % 32'd10);
      n_digits++;
      mag = mag / 32'd10;
    end while (mag != 0);
    if (raw[31]) begin
      ch.code = itd_pkg::CHAR_MINUS;
      ch.is_last = 1'b0;
      text_expected.push_back(ch);
    end
    for (int i = n_digits - 1; i >= 0; i--) begin
      ch.code = itd_pkg::CHAR_ZERO + 6'(digit_stack[i]);
      ch.is_last = (i == 0);
      text_expected.push_back(ch);
    end
  endfunction

  // Random value: mostly a uniformly chosen digit count, sometimes raw bits.
  function automatic logic [31:0] random_value();
    longint lo;
    longint hi;
    int     n_digits;
    bit     neg;
    logic [31:0] mag;
    if ($urandom_range(9) == 0) begin
      return $urandom;
    end
    n_digits = $urandom_range(1, 10);
    neg = 1'($urandom_range(1));
    lo = 1;
    for (int i = 1; i < n_digits; i++) begin
      lo = lo * 10;
    end
    hi = lo * 10 - 1;
    if (n_digits == 1) begin
      lo = 0;
    end
    if (hi > 64'd2147483647) begin
      hi = neg ? 64'd2147483648 : 64'd2147483647;
    end
    mag = $urandom_range(32'(hi), 32'(lo));
    return neg ? (32'd0 - mag) : mag;
  endfunction

  // Sender: holds a beat until taken, then offers the next one unless idling.
  always @(posedge clk) begin
    logic        offer;
    logic [31:0] next_value;
    offer = 1'b0;
    next_value = value;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_ready) begin
      in_valid <= 1'b1;
    end else begin
      if (values_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        offer = 1'b1;
        next_value = values_to_send.pop_front();
      end
      in_valid <= offer;
      value <= next_value;
    end
  end

  // Receiver: random stalls, plus a long hold-off when one is requested.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_req != hold_ack) begin
      hold_ack <= hold_req;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Monitor: predicts on each input beat and checks each character beat.
  always @(posedge clk) begin
    text_char_t want;
    if (!rst) begin
      if (in_valid && in_ready) begin
        predict_text(value);
      end
      if (out_valid && out_ready) begin
        if (text_expected.size() == 0) begin
          report_mismatch($sformatf("unexpected character %0d last %0b",
                                    char_code, last));
        end else begin
          want = text_expected.pop_front();
          if (char_code !== want.code) begin
            report_mismatch($sformatf("char_code %0d, expected %0d",
                                      char_code, want.code));
          end
          if (last !== want.is_last) begin
            report_mismatch($sformatf("last %0b, expected %0b on char %0d",
                                      last, want.is_last, want.code));
          end
        end
      end
    end
  end

  // Waits until every queued value is taken and all its text has come out.
  task automatic wait_drained();
    while (values_to_send.size() != 0 || in_valid || text_expected.size() != 0) begin
      @(negedge clk);
    end
  endtask

  task automatic queue_random(input int count);
    for (int i = 0; i < count; i++) begin
      values_to_send.push_back(random_value());
    end
  endtask

  // Stimulus sequence.
  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed corners: zero, digit count boundaries, both extremes.
    values_to_send.push_back(32'd0);
    values_to_send.push_back(32'd1);
    values_to_send.push_back(-32'sd1);
    values_to_send.push_back(32'd9);
    values_to_send.push_back(32'd10);
    values_to_send.push_back(-32'sd9);
    values_to_send.push_back(-32'sd10);
    values_to_send.push_back(32'd99);
    values_to_send.push_back(32'd100);
    values_to_send.push_back(32'h7FFF_FFFF);
    values_to_send.push_back(32'h8000_0000);
    values_to_send.push_back(32'h8000_0001);
    values_to_send.push_back(32'd999999999);
    values_to_send.push_back(32'd1000000000);
    values_to_send.push_back(-32'sd999999999);
    values_to_send.push_back(-32'sd1000000000);
    values_to_send.push_back(32'd1234567890);
    values_to_send.push_back(-32'sd1234567890);
    values_to_send.push_back(32'h5555_5555);
    values_to_send.push_back(32'hAAAA_AAAA);
    values_to_send.push_back(32'd1000);
    wait_drained();

    // Random values under each idling pattern.
    queue_random(60);
    wait_drained();

    send_idle_pct = 71;
    queue_random(55);
    wait_drained();

    send_idle_pct = 0;
    recv_stall_pct = 71;
    queue_random(55);
    wait_drained();

    send_idle_pct = 20;
    recv_stall_pct = 20;
    queue_random(55);
    wait_drained();

    // Receiver holds off while the sender keeps offering values.
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_req = hold_req + 1;
    queue_random(25);
    wait_drained();

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (text_expected.size() != 0) begin
      report_mismatch($sformatf("%0d characters never arrived", text_expected.size()));
    end
    if (error_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #2_000_000;
    $display("timeout with %0d characters outstanding", text_expected.size());
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
